// ----- sv/assert_macros.svh -----
// Assertion helpers shared by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, skipped while reset is active.
`define HVD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define HVD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/hvd_pkg.sv -----
package hvd_pkg;

    localparam int CORDIC_STEPS = 28;
    localparam int CR_PER_STG   = 4;
    localparam int CR_STG       = CORDIC_STEPS / CR_PER_STG;
    localparam int CW           = 34;

    localparam int SQ_STEPS   = 32;
    localparam int SQ_PER_STG = 2;
    localparam int SQ_STG     = SQ_STEPS / SQ_PER_STG;

    localparam int BRAD_LAT  = 3;
    localparam int ROT_LAT   = CR_STG + 2;
    localparam int VEC_LAT   = CR_STG + 1;
    localparam int SQ_LAT    = SQ_STG;
    localparam int TOTAL_LAT = BRAD_LAT + ROT_LAT + 4 + SQ_LAT + VEC_LAT + 3;

    localparam logic [31:0]        TURN_UNITS  = 32'd3019898880;
    localparam logic [31:0]        BRAD_RECIP  = 32'd3054198966;
    localparam logic signed [32:0] LAT_LIMIT   = 33'sd754974720;
    localparam logic signed [32:0] LON_LIMIT   = 33'sd1509949440;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sh026DD3B6A;
    localparam logic signed [CW-1:0] Q30_ONE     = 34'sh040000000;
    localparam logic [30:0]        PI_Q29      = 31'd1686629713;
    localparam logic [28:0]        DIST_MAX    = 29'h1FFFFFFF;

    typedef struct packed {
        logic vld;
        logic ok;
        logic err;
    } t_tag;

    typedef logic signed [31:0] t_q30;

    function automatic logic signed [CW-1:0] atan_brad(input int idx);
        logic signed [CW-1:0] v;
        case (idx)
            0:  v = 34'sh020000000;
            1:  v = 34'sh012E4051E;
            2:  v = 34'sh009FB385B;
            3:  v = 34'sh0051111D4;
            4:  v = 34'sh0028B0D43;
            5:  v = 34'sh00145D7E1;
            6:  v = 34'sh000A2F61E;
            7:  v = 34'sh000517C55;
            8:  v = 34'sh00028BE53;
            9:  v = 34'sh000145F2F;
            10: v = 34'sh0000A2F98;
            11: v = 34'sh0000517CC;
            12: v = 34'sh000028BE6;
            13: v = 34'sh0000145F3;
            14: v = 34'sh00000A2FA;
            15: v = 34'sh00000517D;
            16: v = 34'sh0000028BE;
            17: v = 34'sh00000145F;
            18: v = 34'sh000000A30;
            19: v = 34'sh000000518;
            20: v = 34'sh00000028C;
            21: v = 34'sh000000146;
            22: v = 34'sh0000000A3;
            23: v = 34'sh000000051;
            24: v = 34'sh000000029;
            25: v = 34'sh000000014;
            26: v = 34'sh00000000A;
            27: v = 34'sh000000005;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [CW-1:0] clamp_q30(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] r;
        if (v > Q30_ONE) begin
            r = Q30_ONE;
        end else if (v < -Q30_ONE) begin
            r = -Q30_ONE;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ----- sv/hvd_brad.sv -----
module hvd_brad (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic signed [33:0] i_diff,
    input  hvd_pkg::t_tag     i_tag,
    output logic [31:0]       o_brad,
    output hvd_pkg::t_tag     o_tag
);
    import hvd_pkg::*;

    localparam logic signed [34:0] T1 = $signed({3'b000, TURN_UNITS});
    localparam logic signed [34:0] T2 = $signed({2'b00, TURN_UNITS, 1'b0});

    logic signed [34:0] w_d;
    logic signed [34:0] n_red;
    logic [31:0]        r_red;
    logic [63:0]        w_prod;
    logic [31:0]        r_q0;
    logic [31:0]        r_n;
    logic [39:0]        w_rem;
    logic [31:0]        n_brad;
    logic [31:0]        r_brad;
    t_tag               r_tag [3];

    assign w_d = 35'(i_diff);

    // reduce into one turn
    always_comb begin
        if (w_d < -T1) begin
            n_red = w_d + T2;
        end else if (w_d < 0) begin
            n_red = w_d + T1;
        end else if (w_d >= T1) begin
            n_red = w_d - T1;
        end else begin
            n_red = w_d;
        end
    end

    // times 64/45: reciprocal estimate, then fix up by at most two
    assign w_prod = 64'(r_red) * 64'(BRAD_RECIP);
    assign w_rem  = 40'({r_n, 6'b000000}) - 40'(r_q0) * 40'd45;

    always_comb begin
        if (w_rem >= 40'd90) begin
            n_brad = r_q0 + 32'd2;
        end else if (w_rem >= 40'd45) begin
            n_brad = r_q0 + 32'd1;
        end else begin
            n_brad = r_q0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_red  <= n_red[31:0];
        r_q0   <= w_prod[62:31];
        r_n    <= r_red;
        r_brad <= n_brad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag[0] <= '0;
            r_tag[1] <= '0;
            r_tag[2] <= '0;
        end else begin
            r_tag[0] <= i_tag;
            r_tag[1] <= r_tag[0];
            r_tag[2] <= r_tag[1];
        end
    end

    assign o_brad = r_brad;
    assign o_tag  = r_tag[2];

endmodule

// ----- sv/hvd_cordic_rot.sv -----
module hvd_cordic_rot (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [31:0]   i_ang,
    input  hvd_pkg::t_tag i_tag,
    output hvd_pkg::t_q30 o_sin,
    output hvd_pkg::t_q30 o_cos,
    output hvd_pkg::t_tag o_tag
);
    import hvd_pkg::*;

    logic signed [CW-1:0] r_x [CR_STG+1];
    logic signed [CW-1:0] r_y [CR_STG+1];
    logic signed [CW-1:0] r_z [CR_STG+1];
    logic                 r_flip [CR_STG+1];
    t_tag                 r_tag [CR_STG+1];
    logic signed [CW-1:0] n_x [CR_STG];
    logic signed [CW-1:0] n_y [CR_STG];
    logic signed [CW-1:0] n_z [CR_STG];

    logic                 w_flip;
    logic [31:0]          w_u;
    logic signed [CW-1:0] w_cx;
    logic signed [CW-1:0] w_sy;
    t_q30                 r_sin;
    t_q30                 r_cos;
    t_tag                 r_tag_out;

    // fold the left half plane onto the right one
    assign w_flip = (i_ang > 32'h40000000) && (i_ang < 32'hC0000000);
    assign w_u    = w_flip ? i_ang + 32'h80000000 : i_ang;

    always_ff @(posedge i_clk) begin
        r_x[0]    <= CORDIC_GAIN;
        r_y[0]    <= '0;
        r_z[0]    <= CW'($signed(w_u));
        r_flip[0] <= w_flip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag[0] <= '0;
        end else begin
            r_tag[0] <= i_tag;
        end
    end

    for (genvar g = 0; g < CR_STG; g++) begin : g_stg
        always_comb begin
            logic signed [CW-1:0] x;
            logic signed [CW-1:0] y;
            logic signed [CW-1:0] z;
            logic signed [CW-1:0] nx;
            x = r_x[g];
            y = r_y[g];
            z = r_z[g];
            for (int k = 0; k < CR_PER_STG; k++) begin
                if (z >= 0) begin
                    nx = x - (y >>> (g * CR_PER_STG + k));
                    y  = y + (x >>> (g * CR_PER_STG + k));
                    z  = z - atan_brad(g * CR_PER_STG + k);
                end else begin
                    nx = x + (y >>> (g * CR_PER_STG + k));
                    y  = y - (x >>> (g * CR_PER_STG + k));
                    z  = z + atan_brad(g * CR_PER_STG + k);
                end
                x = nx;
            end
            n_x[g] = x;
            n_y[g] = y;
            n_z[g] = z;
        end

        always_ff @(posedge i_clk) begin
            r_x[g+1]    <= n_x[g];
            r_y[g+1]    <= n_y[g];
            r_z[g+1]    <= n_z[g];
            r_flip[g+1] <= r_flip[g];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[g+1] <= '0;
            end else begin
                r_tag[g+1] <= r_tag[g];
            end
        end
    end

    assign w_cx = clamp_q30(r_x[CR_STG]);
    assign w_sy = clamp_q30(r_y[CR_STG]);

    always_ff @(posedge i_clk) begin
        r_cos <= 32'(r_flip[CR_STG] ? -w_cx : w_cx);
        r_sin <= 32'(r_flip[CR_STG] ? -w_sy : w_sy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_out <= '0;
        end else begin
            r_tag_out <= r_tag[CR_STG];
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;
    assign o_tag = r_tag_out;

endmodule

// ----- sv/hvd_isqrt.sv -----
module hvd_isqrt (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [63:0]   i_v,
    input  hvd_pkg::t_tag i_tag,
    output logic [30:0]   o_root,
    output hvd_pkg::t_tag o_tag
);
    import hvd_pkg::*;

    logic [63:0] w_rem  [SQ_STG];
    logic [63:0] w_root [SQ_STG];
    t_tag        w_tag  [SQ_STG];
    logic [63:0] n_rem  [SQ_STG];
    logic [63:0] n_root [SQ_STG];
    logic [63:0] r_rem  [SQ_STG];
    logic [63:0] r_root [SQ_STG];
    t_tag        r_tag  [SQ_STG];

    assign w_rem[0]  = i_v;
    assign w_root[0] = '0;
    assign w_tag[0]  = i_tag;

    for (genvar g = 0; g < SQ_STG; g++) begin : g_stg
        if (g > 0) begin : g_link
            assign w_rem[g]  = r_rem[g-1];
            assign w_root[g] = r_root[g-1];
            assign w_tag[g]  = r_tag[g-1];
        end

        // two result bits per stage, bit weight falls by four each step
        always_comb begin
            logic [63:0] rem;
            logic [63:0] root;
            logic [63:0] b;
            rem  = w_rem[g];
            root = w_root[g];
            for (int k = 0; k < SQ_PER_STG; k++) begin
                b = 64'd1 << (62 - 2 * (g * SQ_PER_STG + k));
                if (rem >= root + b) begin
                    rem  = rem - (root + b);
                    root = (root >> 1) + b;
                end else begin
                    root = root >> 1;
                end
            end
            n_rem[g]  = rem;
            n_root[g] = root;
        end

        always_ff @(posedge i_clk) begin
            r_rem[g]  <= n_rem[g];
            r_root[g] <= n_root[g];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[g] <= '0;
            end else begin
                r_tag[g] <= w_tag[g];
            end
        end
    end

    assign o_root = r_root[SQ_STG-1][30:0];
    assign o_tag  = r_tag[SQ_STG-1];

endmodule

// ----- sv/hvd_cordic_vec.sv -----
module hvd_cordic_vec (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [30:0]   i_x,
    input  logic [30:0]   i_y,
    input  hvd_pkg::t_tag i_tag,
    output logic [30:0]   o_ang,
    output hvd_pkg::t_tag o_tag
);
    import hvd_pkg::*;

    logic signed [CW-1:0] w_x [CR_STG];
    logic signed [CW-1:0] w_y [CR_STG];
    logic signed [CW-1:0] w_z [CR_STG];
    t_tag                 w_tag [CR_STG];
    logic signed [CW-1:0] n_x [CR_STG];
    logic signed [CW-1:0] n_y [CR_STG];
    logic signed [CW-1:0] n_z [CR_STG];
    logic signed [CW-1:0] r_x [CR_STG];
    logic signed [CW-1:0] r_y [CR_STG];
    logic signed [CW-1:0] r_z [CR_STG];
    t_tag                 r_tag [CR_STG];
    logic signed [CW-1:0] w_h;
    logic [30:0]          r_ang;
    t_tag                 r_tag_out;

    assign w_x[0]   = CW'(i_x);
    assign w_y[0]   = CW'(i_y);
    assign w_z[0]   = '0;
    assign w_tag[0] = i_tag;

    for (genvar g = 0; g < CR_STG; g++) begin : g_stg
        if (g > 0) begin : g_link
            assign w_x[g]   = r_x[g-1];
            assign w_y[g]   = r_y[g-1];
            assign w_z[g]   = r_z[g-1];
            assign w_tag[g] = r_tag[g-1];
        end

        // drive y toward zero, accumulate the angle
        always_comb begin
            logic signed [CW-1:0] x;
            logic signed [CW-1:0] y;
            logic signed [CW-1:0] z;
            logic signed [CW-1:0] nx;
            x = w_x[g];
            y = w_y[g];
            z = w_z[g];
            for (int k = 0; k < CR_PER_STG; k++) begin
                if (y > 0) begin
                    nx = x + (y >>> (g * CR_PER_STG + k));
                    y  = y - (x >>> (g * CR_PER_STG + k));
                    z  = z + atan_brad(g * CR_PER_STG + k);
                end else begin
                    nx = x - (y >>> (g * CR_PER_STG + k));
                    y  = y + (x >>> (g * CR_PER_STG + k));
                    z  = z - atan_brad(g * CR_PER_STG + k);
                end
                x = nx;
            end
            n_x[g] = x;
            n_y[g] = y;
            n_z[g] = z;
        end

        always_ff @(posedge i_clk) begin
            r_x[g] <= n_x[g];
            r_y[g] <= n_y[g];
            r_z[g] <= n_z[g];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[g] <= '0;
            end else begin
                r_tag[g] <= w_tag[g];
            end
        end
    end

    // clamp to a quarter turn
    always_comb begin
        if (r_z[CR_STG-1] < 0) begin
            w_h = '0;
        end else if (r_z[CR_STG-1] > Q30_ONE) begin
            w_h = Q30_ONE;
        end else begin
            w_h = r_z[CR_STG-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_ang <= w_h[30:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_out <= '0;
        end else begin
            r_tag_out <= r_tag[CR_STG-1];
        end
    end

    assign o_ang = r_ang;
    assign o_tag = r_tag_out;

endmodule

// ----- sv/haversine_distance_from_reference_top.sv -----
// Channel    Direction  Ports                                        Handshake
// command    in         i_cur_latitude, i_cur_longitude              i_start / o_busy
// result     out        o_distance, o_valid_res, o_range_error       o_done strobe
// config     in         i_cfg_addr, i_cfg_wdata                      i_cfg_we
//
// One transaction enters per cycle; o_busy stays low, the pipeline never stalls.
// Each result passes the brad, rotation CORDIC, haversine multiply, square root,
// vectoring CORDIC and scale registers: 28-step CORDICs, a 32-step root, all pipelined.
// Synchronous active-low reset clears the valid chain and resets the config registers.
// The receiver cannot stall; a result is shown for exactly one cycle on o_done.
module haversine_distance_from_reference_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic signed [30:0] i_cur_latitude,
    input  logic signed [31:0] i_cur_longitude,
    output logic               o_done,
    output logic [28:0]        o_distance,
    output logic               o_valid_res,
    output logic               o_range_error,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_addr,
    input  logic [31:0]        i_cfg_wdata
);
    import hvd_pkg::*;

    localparam logic [1:0] REG_REF_ENABLE = 2'd0;
    localparam logic [1:0] REG_REF_LAT    = 2'd1;
    localparam logic [1:0] REG_REF_LON    = 2'd2;
    localparam logic [1:0] REG_RADIUS     = 2'd3;

    // Config registers
    logic               r_ref_en;
    logic signed [30:0] r_ref_lat;
    logic signed [31:0] r_ref_lon;
    logic [22:0]        r_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_en  <= 1'b0;
            r_ref_lat <= '0;
            r_ref_lon <= '0;
            r_radius  <= 23'd6371000;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_REF_ENABLE: r_ref_en  <= i_cfg_wdata[0];
                REG_REF_LAT:    r_ref_lat <= i_cfg_wdata[30:0];
                REG_REF_LON:    r_ref_lon <= i_cfg_wdata;
                REG_RADIUS:     r_radius  <= i_cfg_wdata[22:0];
                default: ;
            endcase
        end
    end

    // Front end: range check and angle differences
    logic               w_err;
    t_tag               w_tag_in;
    logic signed [33:0] w_dlat;
    logic signed [33:0] w_dlon;

    assign o_busy = 1'b0;

    assign w_err = (33'(i_cur_latitude) > LAT_LIMIT) || (33'(i_cur_latitude) < -LAT_LIMIT)
                || (33'(i_cur_longitude) > LON_LIMIT) || (33'(i_cur_longitude) < -LON_LIMIT);

    assign w_tag_in.vld = i_start;
    assign w_tag_in.ok  = r_ref_en && !w_err;
    assign w_tag_in.err = w_err;

    assign w_dlat = 34'(r_ref_lat) - 34'(i_cur_latitude);
    assign w_dlon = 34'(r_ref_lon) - 34'(i_cur_longitude);

    // Binary angles, four lanes
    logic [31:0] w_b_dlat, w_b_dlon, w_b_lat, w_b_rlat;
    t_tag        w_tag_b;

    hvd_brad u_brad_dlat (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_diff(w_dlat), .i_tag(w_tag_in),
        .o_brad(w_b_dlat), .o_tag(w_tag_b)
    );
    hvd_brad u_brad_dlon (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_diff(w_dlon), .i_tag(w_tag_in),
        .o_brad(w_b_dlon), .o_tag()
    );
    hvd_brad u_brad_lat (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_diff(34'(i_cur_latitude)), .i_tag(w_tag_in),
        .o_brad(w_b_lat), .o_tag()
    );
    hvd_brad u_brad_rlat (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_diff(34'(r_ref_lat)), .i_tag(w_tag_in),
        .o_brad(w_b_rlat), .o_tag()
    );

    // Sine of the half differences, cosine of both latitudes
    t_q30 w_s1, w_s2, w_c1, w_c2;
    t_q30 w_unused_c_a, w_unused_c_b, w_unused_s_a, w_unused_s_b;
    t_tag w_tag_r;

    hvd_cordic_rot u_rot_dlat (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ang(w_b_dlat >> 1), .i_tag(w_tag_b),
        .o_sin(w_s1), .o_cos(w_unused_c_a), .o_tag(w_tag_r)
    );
    hvd_cordic_rot u_rot_dlon (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ang(w_b_dlon >> 1), .i_tag(w_tag_b),
        .o_sin(w_s2), .o_cos(w_unused_c_b), .o_tag()
    );
    hvd_cordic_rot u_rot_lat (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ang(w_b_lat), .i_tag(w_tag_b),
        .o_sin(w_unused_s_a), .o_cos(w_c1), .o_tag()
    );
    hvd_cordic_rot u_rot_rlat (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ang(w_b_rlat), .i_tag(w_tag_b),
        .o_sin(w_unused_s_b), .o_cos(w_c2), .o_tag()
    );

    // Haversine term: a = s1^2 + s2^2 * c1 * c2, both squares in the first stage, then one multiply per stage
    logic signed [63:0] w_sq1, w_sq2, w_m3, w_m4;
    t_q30               r_p1, r_p1_d, r_p1_dd, r_p2, r_p3, r_p4;
    t_q30               r_c1_d, r_c2_d, r_c2_dd;
    t_tag               r_tag_m1, r_tag_m2, r_tag_m3, r_tag_a;
    logic signed [32:0] w_asum;
    logic [30:0]        w_a;
    logic [30:0]        r_a, r_na;

    assign w_sq1 = 64'(w_s1) * 64'(w_s1);
    assign w_sq2 = 64'(w_s2) * 64'(w_s2);
    assign w_m3  = 64'(r_p2) * 64'(r_c1_d);
    assign w_m4  = 64'(r_p3) * 64'(r_c2_dd);
    assign w_asum = 33'(r_p1_dd) + 33'(r_p4);

    // clamp to [0, 1]
    always_comb begin
        if (w_asum < 0) begin
            w_a = '0;
        end else if (w_asum > 33'(Q30_ONE)) begin
            w_a = 31'(Q30_ONE);
        end else begin
            w_a = w_asum[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1    <= w_sq1[61:30];
        r_p2    <= w_sq2[61:30];
        r_c1_d  <= w_c1;
        r_c2_d  <= w_c2;
        r_p3    <= w_m3[61:30];
        r_p1_d  <= r_p1;
        r_c2_dd <= r_c2_d;
        r_p4    <= w_m4[61:30];
        r_p1_dd <= r_p1_d;
        r_a     <= w_a;
        r_na    <= 31'(Q30_ONE) - w_a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_m1 <= '0;
            r_tag_m2 <= '0;
            r_tag_m3 <= '0;
            r_tag_a  <= '0;
        end else begin
            r_tag_m1 <= w_tag_r;
            r_tag_m2 <= r_tag_m1;
            r_tag_m3 <= r_tag_m2;
            r_tag_a  <= r_tag_m3;
        end
    end

    // Square roots of a and 1-a
    logic [30:0] w_ra, w_rb;
    t_tag        w_tag_sq;

    hvd_isqrt u_sqrt_a (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_v({3'b000, r_a, 30'd0}), .i_tag(r_tag_a),
        .o_root(w_ra), .o_tag(w_tag_sq)
    );
    hvd_isqrt u_sqrt_na (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_v({3'b000, r_na, 30'd0}), .i_tag(r_tag_a),
        .o_root(w_rb), .o_tag()
    );

    // Half central angle
    logic [30:0] w_h;
    t_tag        w_tag_h;

    hvd_cordic_vec u_vec (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_x(w_rb), .i_y(w_ra), .i_tag(w_tag_sq),
        .o_ang(w_h), .o_tag(w_tag_h)
    );

    // Scale: R * h * pi, split so no multiply exceeds 32 bits by 32 bits
    logic [53:0] r_prod;
    logic [58:0] r_hp;
    logic [56:0] r_lp;
    logic [60:0] w_acc;
    logic [28:0] w_dist;
    t_tag        r_tag_r1, r_tag_r2;

    assign w_acc  = 61'(r_hp) + 61'(r_lp[56:26]) + (61'd1 << 28);
    assign w_dist = (|w_acc[60:58]) ? DIST_MAX : w_acc[57:29];

    always_ff @(posedge i_clk) begin
        r_prod <= 54'(r_radius) * 54'(w_h);
        r_hp   <= 59'(r_prod[53:26]) * 59'(PI_Q29);
        r_lp   <= 57'(r_prod[25:0]) * 57'(PI_Q29);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_r1 <= '0;
            r_tag_r2 <= '0;
        end else begin
            r_tag_r1 <= w_tag_h;
            r_tag_r2 <= r_tag_r1;
        end
    end

    // Output register: drop the distance when the transaction is not valid
    logic        r_done;
    logic [28:0] r_distance;
    logic        r_valid_res;
    logic        r_range_error;

    always_ff @(posedge i_clk) begin
        r_distance    <= r_tag_r2.ok ? w_dist : '0;
        r_valid_res   <= r_tag_r2.ok;
        r_range_error <= r_tag_r2.err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_tag_r2.vld;
        end
    end

    assign o_done        = r_done;
    assign o_distance    = r_distance;
    assign o_valid_res   = r_valid_res;
    assign o_range_error = r_range_error;

endmodule

// ----- sv/hvd_chk.sv -----
`include "assert_macros.svh"

module hvd_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_start,
    input logic               o_busy,
    input logic signed [30:0] i_cur_latitude,
    input logic signed [31:0] i_cur_longitude,
    input logic               o_done,
    input logic [28:0]        o_distance,
    input logic               o_valid_res,
    input logic               o_range_error,
    input logic               i_cfg_we,
    input logic [1:0]         i_cfg_addr,
    input logic [31:0]        i_cfg_wdata
);
    import hvd_pkg::*;

    `HVD_ASSERT(a_valid_no_err, i_clk, i_rst_n, (o_done |-> !(o_valid_res && o_range_error)), "valid result flagged as range error")
    `HVD_ASSERT(a_invalid_zero, i_clk, i_rst_n, ((o_done && !o_valid_res) |-> (o_distance == '0)), "invalid result carries a distance")
    `HVD_ASSERT(a_done_has_start, i_clk, i_rst_n, (o_done |-> $past(i_start, TOTAL_LAT)), "result without a matching transaction")
    `HVD_ASSERT_ALWAYS(a_reset_quiet, i_clk, ($rose(i_rst_n) |-> !o_done), "result strobe right after reset")

endmodule

bind haversine_distance_from_reference_top hvd_chk u_hvd_chk (.*);
